[rtl/so2_oscillator_step_unit_assert.svh]
// assertion macros shared by the oscillator step unit
`ifndef SO2_OSCILLATOR_STEP_UNIT_ASSERT_SVH
`define SO2_OSCILLATOR_STEP_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SO2_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("so2 oscillator check failed");

// next-cycle implication, disabled while reset is held
`define SO2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("so2 oscillator check failed");

`endif

[rtl/so2osc_pkg.sv]
// shared types, constants and helpers of the so2 oscillator step unit
package so2osc_pkg;

    localparam int DEF_TANH_TABLE_DEPTH = 1024;
    localparam int DEF_DATA_WIDTH       = 16;

    localparam int REG_WIDTH     = 16;  // configuration registers, q4.12
    localparam int TANH_WIDTH    = 13;  // table entry magnitude
    localparam int OUT_WIDTH     = 14;  // signed tanh output
    localparam int ACT_OUT_WIDTH = 16;  // activation fields on the result
    localparam int FRAC_BITS     = 12;
    localparam int PROD_WIDTH    = REG_WIDTH + OUT_WIDTH;
    localparam int ACC_WIDTH     = 32;
    localparam int WIDE_W        = 33;  // holds any activation before saturation
    localparam int CFG_IDX_WIDTH = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 64;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_W_SELF_FIRST,
        REG_W_CROSS_FIRST,
        REG_W_SELF_SECOND,
        REG_W_CROSS_SECOND,
        REG_BIAS_FIRST,
        REG_BIAS_SECOND,
        REG_START_ACT_FIRST,
        REG_START_ACT_SECOND
    } t_reg_idx;

    localparam logic signed [REG_WIDTH-1:0] RST_W_SELF_FIRST     = 16'sd4096;
    localparam logic signed [REG_WIDTH-1:0] RST_W_CROSS_FIRST    = 16'sd0;
    localparam logic signed [REG_WIDTH-1:0] RST_W_SELF_SECOND    = 16'sd4096;
    localparam logic signed [REG_WIDTH-1:0] RST_W_CROSS_SECOND   = 16'sd0;
    localparam logic signed [REG_WIDTH-1:0] RST_BIAS_FIRST       = 16'sd0;
    localparam logic signed [REG_WIDTH-1:0] RST_BIAS_SECOND      = 16'sd0;
    localparam logic signed [REG_WIDTH-1:0] RST_START_ACT_FIRST  = 16'sd410;
    localparam logic signed [REG_WIDTH-1:0] RST_START_ACT_SECOND = 16'sd0;

    typedef struct packed {
        logic signed [REG_WIDTH-1:0] w_self_first;
        logic signed [REG_WIDTH-1:0] w_cross_first;
        logic signed [REG_WIDTH-1:0] w_self_second;
        logic signed [REG_WIDTH-1:0] w_cross_second;
        logic signed [REG_WIDTH-1:0] bias_first;
        logic signed [REG_WIDTH-1:0] bias_second;
        logic signed [REG_WIDTH-1:0] start_act_first;
        logic signed [REG_WIDTH-1:0] start_act_second;
    } t_cfg;

    // clamp a wide value to the signed range of a dw-bit activation
    function automatic logic signed [WIDE_W-1:0] sat_wide(
        input logic signed [WIDE_W-1:0] v,
        input int                       dw
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'((longint'(1) <<< (dw - 1)) - longint'(1));
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

[rtl/so2_cfg_regs.sv]
// configuration register file with write decoder
module so2_cfg_regs
    import so2osc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [REG_WIDTH-1:0]     i_cfg_data,
    output t_cfg                     o_cfg,
    output t_cfg                     o_cfg_next
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_W_SELF_FIRST:     n_cfg.w_self_first     = i_cfg_data;
                REG_W_CROSS_FIRST:    n_cfg.w_cross_first    = i_cfg_data;
                REG_W_SELF_SECOND:    n_cfg.w_self_second    = i_cfg_data;
                REG_W_CROSS_SECOND:   n_cfg.w_cross_second   = i_cfg_data;
                REG_BIAS_FIRST:       n_cfg.bias_first       = i_cfg_data;
                REG_BIAS_SECOND:      n_cfg.bias_second      = i_cfg_data;
                REG_START_ACT_FIRST:  n_cfg.start_act_first  = i_cfg_data;
                REG_START_ACT_SECOND: n_cfg.start_act_second = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.w_self_first     <= RST_W_SELF_FIRST;
            r_cfg.w_cross_first    <= RST_W_CROSS_FIRST;
            r_cfg.w_self_second    <= RST_W_SELF_SECOND;
            r_cfg.w_cross_second   <= RST_W_CROSS_SECOND;
            r_cfg.bias_first       <= RST_BIAS_FIRST;
            r_cfg.bias_second      <= RST_BIAS_SECOND;
            r_cfg.start_act_first  <= RST_START_ACT_FIRST;
            r_cfg.start_act_second <= RST_START_ACT_SECOND;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg      = r_cfg;
    assign o_cfg_next = n_cfg;

endmodule

[rtl/so2_neuron.sv]
// one neuron update: weighted outputs plus bias, rounded and saturated
module so2_neuron
    import so2osc_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic signed [REG_WIDTH-1:0]  i_w_self,
    input  logic signed [REG_WIDTH-1:0]  i_w_cross,
    input  logic signed [REG_WIDTH-1:0]  i_bias,
    input  logic signed [OUT_WIDTH-1:0]  i_own,
    input  logic signed [OUT_WIDTH-1:0]  i_other,
    output logic signed [DATA_WIDTH-1:0] o_act
);

    logic signed [PROD_WIDTH-1:0] p_self;
    logic signed [PROD_WIDTH-1:0] p_cross;
    logic signed [ACC_WIDTH-1:0]  acc;
    logic signed [ACC_WIDTH-1:0]  rounded;
    logic signed [WIDE_W-1:0]     sat;

    assign p_self  = i_w_self * i_own;
    assign p_cross = i_w_cross * i_other;
    assign acc     = ACC_WIDTH'(p_self) + ACC_WIDTH'(p_cross)
                   + (ACC_WIDTH'(i_bias) <<< FRAC_BITS);
    // half up: add half an lsb, then floor
    assign rounded = (acc + (ACC_WIDTH'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign sat     = sat_wide(WIDE_W'(rounded), DATA_WIDTH);
    assign o_act   = sat[DATA_WIDTH-1:0];

endmodule

[rtl/so2_tanh_rom.sv]
// tanh table with two registered read ports, addressed by signed activation
module so2_tanh_rom
    import so2osc_pkg::*;
#(
    parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH,
    parameter int DATA_WIDTH       = DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic signed [DATA_WIDTH-1:0] i_act_a,
    input  logic signed [DATA_WIDTH-1:0] i_act_b,
    output logic signed [OUT_WIDTH-1:0]  o_tanh_a,
    output logic signed [OUT_WIDTH-1:0]  o_tanh_b
);

    localparam int ADDR_W  = $clog2(TANH_TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int PROD_W  = DATA_WIDTH + DEPTH_W;
    // exp step of 16/depth in q0.32
    localparam longint unsigned STEP_ARG = (64'd1 << 36) / TANH_TABLE_DEPTH;

    typedef logic [TANH_TABLE_DEPTH-1:0][TANH_WIDTH-1:0] t_lut;

    // shift-and-subtract quotient, only evaluated while the table is built
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // entry k = tanh(8k/depth) in q.12, via a running power of exp(-16/depth)
    function automatic t_lut build_lut(input longint unsigned y);
        t_lut            lut;
        longint unsigned term;
        longint          bsum;
        longint unsigned b;
        longint unsigned t;
        longint unsigned num;
        longint unsigned den;
        lut  = '0;
        term = 64'd1 << 32;
        bsum = 0;
        for (int n = 0; n < 20; n++) begin
            if (n[0]) begin
                bsum = bsum - longint'(term);
            end else begin
                bsum = bsum + longint'(term);
            end
            term = udiv64((term * y) >> 32, 64'(n + 1));
        end
        if (bsum < 0) begin
            bsum = 0;
        end
        if (bsum > (longint'(1) <<< 32)) begin
            bsum = longint'(1) <<< 32;
        end
        b = longint'(bsum);
        t = 64'd1 << 32;
        for (int k = 0; k < TANH_TABLE_DEPTH; k++) begin
            num    = 64'd8192 * ((64'd1 << 32) - t) + (64'd1 << 32) + t;
            den    = 64'd2 * ((64'd1 << 32) + t);
            lut[k] = TANH_WIDTH'(udiv64(num, den));
            t      = (t * b) >> 32;
        end
        return lut;
    endfunction

    localparam t_lut LUT = build_lut(STEP_ARG);

    function automatic logic [ADDR_W-1:0] tanh_index(input logic signed [DATA_WIDTH-1:0] a);
        logic [DATA_WIDTH-1:0] mag;
        logic [PROD_W-1:0]     scaled;
        mag    = a[DATA_WIDTH-1] ? (~a + DATA_WIDTH'(1)) : a;
        scaled = (PROD_W'(mag) * PROD_W'(TANH_TABLE_DEPTH)) >> 15;
        if (scaled > PROD_W'(TANH_TABLE_DEPTH - 1)) begin
            scaled = PROD_W'(TANH_TABLE_DEPTH - 1);
        end
        return scaled[ADDR_W-1:0];
    endfunction

    logic [TANH_WIDTH-1:0] r_entry_a;
    logic [TANH_WIDTH-1:0] r_entry_b;
    logic                  r_neg_a;
    logic                  r_neg_b;

    always_ff @(posedge i_clk) begin
        r_entry_a <= LUT[tanh_index(i_act_a)];
        r_entry_b <= LUT[tanh_index(i_act_b)];
        r_neg_a   <= i_act_a[DATA_WIDTH-1];
        r_neg_b   <= i_act_b[DATA_WIDTH-1];
    end

    // odd symmetry restored after the read
    assign o_tanh_a = r_neg_a ? -$signed({1'b0, r_entry_a}) : $signed({1'b0, r_entry_a});
    assign o_tanh_b = r_neg_b ? -$signed({1'b0, r_entry_b}) : $signed({1'b0, r_entry_b});

endmodule

[rtl/so2_oscillator_step_unit.sv]
// two-neuron so(2) oscillator: one step per input transaction
//
// slave side (i_s_*): one transaction per oscillator tick; bit 0 of tdata is the
// restart flag, which reloads both activations from the start registers first.
// master side (o_m_*): one result per tick with both tanh outputs and both new
// activations. configuration is a plain write port (enable, index, data); the user
// must write it only while no tick is in flight, as the block does not enforce this.
// an accepted tick waits in the input register, and its result is registered into
// the output register once that register is free.
// throughput: one tick per cycle while the master side does not stall. the state
// loop closes through the new activations, which address the tanh table directly, so
// the table's registered read lands together with the activation register.
// reset: synchronous, active low; activations return to zero, registers to
// their defaults, both stages empty, and tready is held low during reset.
// stall: the output register holds its result while i_m_tready is low; one
// more tick waits in the input register, then o_s_tready drops.
module so2_oscillator_step_unit
    import so2osc_pkg::*;
#(
    parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH,
    parameter int DATA_WIDTH       = DEF_DATA_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave stream
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_TDATA_W-1:0]    i_s_tdata,   // [0] restart, [7:1] zero
    // master stream
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_TDATA_W-1:0]   o_m_tdata,   // [13:0] out_first, [27:14] out_second,
                                                  // [43:28] act_first_next,
                                                  // [59:44] act_second_next, [63:60] zero
    // configuration writes
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [REG_WIDTH-1:0]     i_cfg_data
);

`include "so2_oscillator_step_unit_assert.svh"

    t_cfg cfg;
    t_cfg cfg_next;

    logic r_in_valid;
    logic r_restart;
    logic r_out_valid;
    logic fire;

    logic signed [DATA_WIDTH-1:0] r_act_first;
    logic signed [DATA_WIDTH-1:0] r_act_second;
    logic signed [DATA_WIDTH-1:0] n_act_first;
    logic signed [DATA_WIDTH-1:0] n_act_second;
    logic signed [DATA_WIDTH-1:0] upd_first;
    logic signed [DATA_WIDTH-1:0] upd_second;
    logic signed [DATA_WIDTH-1:0] start_first;
    logic signed [DATA_WIDTH-1:0] start_second;
    logic signed [WIDE_W-1:0]     start_first_wide;
    logic signed [WIDE_W-1:0]     start_second_wide;

    logic signed [OUT_WIDTH-1:0] act_tanh_first;
    logic signed [OUT_WIDTH-1:0] act_tanh_second;
    logic signed [OUT_WIDTH-1:0] start_tanh_first;
    logic signed [OUT_WIDTH-1:0] start_tanh_second;
    logic signed [OUT_WIDTH-1:0] tanh_first;
    logic signed [OUT_WIDTH-1:0] tanh_second;

    logic signed [ACT_OUT_WIDTH-1:0] act_out_first;
    logic signed [ACT_OUT_WIDTH-1:0] act_out_second;

    logic signed [OUT_WIDTH-1:0]     r_out_first;
    logic signed [OUT_WIDTH-1:0]     r_out_second;
    logic signed [ACT_OUT_WIDTH-1:0] r_out_act_first;
    logic signed [ACT_OUT_WIDTH-1:0] r_out_act_second;

    so2_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cfg_next  (cfg_next)
    );

    // start values clamped to the activation range; taken from the write
    // path so the table read is current right after a write
    assign start_first_wide  = sat_wide(WIDE_W'(cfg_next.start_act_first), DATA_WIDTH);
    assign start_second_wide = sat_wide(WIDE_W'(cfg_next.start_act_second), DATA_WIDTH);
    assign start_first       = start_first_wide[DATA_WIDTH-1:0];
    assign start_second      = start_second_wide[DATA_WIDTH-1:0];

    so2_tanh_rom #(
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
        .DATA_WIDTH       (DATA_WIDTH)
    ) u_rom_first (
        .i_clk    (i_clk),
        .i_act_a  (n_act_first),
        .i_act_b  (start_first),
        .o_tanh_a (act_tanh_first),
        .o_tanh_b (start_tanh_first)
    );

    so2_tanh_rom #(
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
        .DATA_WIDTH       (DATA_WIDTH)
    ) u_rom_second (
        .i_clk    (i_clk),
        .i_act_a  (n_act_second),
        .i_act_b  (start_second),
        .o_tanh_a (act_tanh_second),
        .o_tanh_b (start_tanh_second)
    );

    assign tanh_first  = r_restart ? start_tanh_first  : act_tanh_first;
    assign tanh_second = r_restart ? start_tanh_second : act_tanh_second;

    so2_neuron #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_neuron_first (
        .i_w_self  (cfg.w_self_first),
        .i_w_cross (cfg.w_cross_first),
        .i_bias    (cfg.bias_first),
        .i_own     (tanh_first),
        .i_other   (tanh_second),
        .o_act     (upd_first)
    );

    so2_neuron #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_neuron_second (
        .i_w_self  (cfg.w_self_second),
        .i_w_cross (cfg.w_cross_second),
        .i_bias    (cfg.bias_second),
        .i_own     (tanh_second),
        .i_other   (tanh_first),
        .o_act     (upd_second)
    );

    assign fire         = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready   = i_rst_n && (!r_in_valid || fire);
    assign n_act_first  = fire ? upd_first  : r_act_first;
    assign n_act_second = fire ? upd_second : r_act_second;

    generate
        if (DATA_WIDTH >= ACT_OUT_WIDTH) begin : g_act_trunc
            assign act_out_first  = upd_first[ACT_OUT_WIDTH-1:0];
            assign act_out_second = upd_second[ACT_OUT_WIDTH-1:0];
        end else begin : g_act_ext
            assign act_out_first  = ACT_OUT_WIDTH'(upd_first);
            assign act_out_second = ACT_OUT_WIDTH'(upd_second);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_act_first  <= '0;
            r_act_second <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_act_first  <= n_act_first;
            r_act_second <= n_act_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_restart <= i_s_tdata[0];
        end
        if (fire) begin
            r_out_first      <= tanh_first;
            r_out_second     <= tanh_second;
            r_out_act_first  <= act_out_first;
            r_out_act_second <= act_out_second;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_act_second, r_out_act_first, r_out_second, r_out_first};

    // the result on show always carries the activation now held as state
    `SO2_ASSERT_NOW(a_out_act_tracks_state, i_clk, i_rst_n,
        r_out_valid, r_out_act_first == ACT_OUT_WIDTH'(r_act_first))

    `SO2_ASSERT_NOW(a_tanh_in_range, i_clk, i_rst_n,
        r_out_valid, (r_out_first <= 14'sd4096) && (r_out_first >= -14'sd4096))

    `SO2_ASSERT_NOW(a_full_stall_blocks_input, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_m_tready, !o_s_tready)

    `SO2_ASSERT_NEXT(a_waiting_tick_kept, i_clk, i_rst_n,
        r_in_valid && !fire, r_in_valid)

endmodule

[verif/so2_oscillator_step_unit_test.sv]
// self-checking stream testbench for the so2 oscillator step unit
module so2_oscillator_step_unit_test;
    import so2osc_pkg::*;

    localparam int     TANH_DEPTH  = DEF_TANH_TABLE_DEPTH;
    localparam int     ACT_W       = DEF_DATA_WIDTH;
    localparam longint ACT_MAX     = (longint'(1) << (ACT_W - 1)) - 1;
    localparam longint ACT_MIN     = -ACT_MAX - 1;
    localparam int     STUCK_LIMIT = 3000;
    localparam int     N_DIRECTED  = 21;
    localparam int     N_PHASES    = 9;
    localparam int     PHASE_TICKS = 60;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0]     out_first;
        logic signed [OUT_WIDTH-1:0]     out_second;
        logic signed [ACT_OUT_WIDTH-1:0] act_first_next;
        logic signed [ACT_OUT_WIDTH-1:0] act_second_next;
    } t_tick_result;

    typedef struct {
        int cfg_set;
        bit restart;
        bit typed;
        int out_first;
        int out_second;
        int act_first;
        int act_second;
    } t_tick_row;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_s_tvalid  = 1'b0;
    logic                     o_s_tready;
    logic [IN_TDATA_W-1:0]    i_s_tdata   = '0;
    logic                     o_m_tvalid;
    logic                     i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]   o_m_tdata;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index = REG_W_SELF_FIRST;
    logic [REG_WIDTH-1:0]     i_cfg_data  = '0;

    so2_oscillator_step_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // oscillator state as the block should hold it
    int unsigned  tanh_mag_lut [TANH_DEPTH];
    t_cfg         osc_cfg;
    longint       osc_act_first;
    longint       osc_act_second;
    t_tick_result tick_results_due [$];

    int fault_count  = 0;
    int stuck_cycles = 0;
    int rx_hold      = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_stall_on  = 1'b1;

    // order per set: w_self, w_cross, w_self, w_cross, bias, bias, start, start
    t_cfg directed_cfgs [5] = '{
        '{RST_W_SELF_FIRST, RST_W_CROSS_FIRST, RST_W_SELF_SECOND, RST_W_CROSS_SECOND,
          RST_BIAS_FIRST, RST_BIAS_SECOND, RST_START_ACT_FIRST, RST_START_ACT_SECOND},
        '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
          16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000},
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1234, -16'sd1, 16'sd0, 16'sd0},
        '{16'sd64, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd0, -16'sd40, 16'sd40}
    };

    t_tick_row directed_rows [N_DIRECTED] = '{
        '{0, 1'b0, 1'b1, 0, 0, 0, 0},
        '{0, 1'b0, 1'b1, 0, 0, 0, 0},
        '{0, 1'b1, 1'b0, 0, 0, 0, 0},
        '{0, 1'b0, 1'b0, 0, 0, 0, 0},
        '{0, 1'b0, 1'b0, 0, 0, 0, 0},
        '{0, 1'b0, 1'b0, 0, 0, 0, 0},
        // positive and negative saturation, table index past the end
        '{1, 1'b1, 1'b1, 4096, -4096, 32767, -32768},
        '{1, 1'b0, 1'b1, 4096, -4096, 32767, -32768},
        '{1, 1'b0, 1'b1, 4096, -4096, 32767, -32768},
        '{2, 1'b1, 1'b1, -4096, -4096, 32767, 32767},
        '{2, 1'b0, 1'b1, 4096, 4096, -32768, -32768},
        '{2, 1'b0, 1'b1, -4096, -4096, 32767, 32767},
        // bias only
        '{3, 1'b1, 1'b1, 0, 0, 1234, -1},
        '{3, 1'b0, 1'b0, 0, 0, 0, 0},
        '{3, 1'b0, 1'b0, 0, 0, 0, 0},
        // exact halves: -0.5 rounds up to zero, +0.5 up to one
        '{4, 1'b1, 1'b1, -32, 32, 0, 1},
        '{4, 1'b0, 1'b0, 0, 0, 0, 0},
        '{4, 1'b0, 1'b0, 0, 0, 0, 0},
        '{0, 1'b1, 1'b0, 0, 0, 0, 0},
        '{0, 1'b0, 1'b0, 0, 0, 0, 0},
        '{0, 1'b0, 1'b0, 0, 0, 0, 0}
    };

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic longint tanh_lookup(longint a);
        longint mag;
        longint idx;
        longint e;
        mag = (a < 0) ? -a : a;
        idx = (mag * TANH_DEPTH) >>> 15;
        if (idx > TANH_DEPTH - 1) begin
            idx = TANH_DEPTH - 1;
        end
        e = longint'(tanh_mag_lut[idx]);
        return (a < 0) ? -e : e;
    endfunction

    function automatic longint neuron_next(longint w_own, longint own, longint w_other,
                                           longint other, longint bias);
        longint acc;
        acc = w_own * own + w_other * other + bias * (longint'(1) << FRAC_BITS);
        acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (acc > ACT_MAX) begin
            return ACT_MAX;
        end else if (acc < ACT_MIN) begin
            return ACT_MIN;
        end
        return acc;
    endfunction

    function automatic t_tick_result predict_tick(bit restart);
        t_tick_result res;
        longint       o1;
        longint       o2;
        if (restart) begin
            osc_act_first  = $signed(osc_cfg.start_act_first);
            osc_act_second = $signed(osc_cfg.start_act_second);
        end
        o1 = tanh_lookup(osc_act_first);
        o2 = tanh_lookup(osc_act_second);
        osc_act_first  = neuron_next($signed(osc_cfg.w_self_first), o1,
                                     $signed(osc_cfg.w_cross_first), o2,
                                     $signed(osc_cfg.bias_first));
        osc_act_second = neuron_next($signed(osc_cfg.w_self_second), o2,
                                     $signed(osc_cfg.w_cross_second), o1,
                                     $signed(osc_cfg.bias_second));
        res.out_first       = OUT_WIDTH'(o1);
        res.out_second      = OUT_WIDTH'(o2);
        res.act_first_next  = ACT_OUT_WIDTH'(osc_act_first);
        res.act_second_next = ACT_OUT_WIDTH'(osc_act_second);
        return res;
    endfunction

    function automatic logic [REG_WIDTH-1:0] corner_or_random();
        case ($urandom_range(0, 5))
            0: begin
                return 16'h8000;
            end
            1: begin
                return 16'h7FFF;
            end
            2: begin
                return 16'h0000;
            end
            3: begin
                return 16'hFFFF;
            end
            4: begin
                return 16'h1000;
            end
            default: begin
                return REG_WIDTH'($urandom);
            end
        endcase
    endfunction

    // 0: anything, 1: weights that keep it oscillating, 2: corners mixed in
    function automatic t_cfg rand_cfg(int style);
        t_cfg c;
        int   m;
        if (style == 1) begin
            m = $urandom_range(300, 2500);
            if ($urandom_range(0, 1)) begin
                m = -m;
            end
            c.w_self_first     = REG_WIDTH'($urandom_range(4500, 6200));
            c.w_self_second    = REG_WIDTH'($urandom_range(4500, 6200));
            c.w_cross_first    = REG_WIDTH'(m);
            c.w_cross_second   = REG_WIDTH'(-m);
            c.bias_first       = REG_WIDTH'(int'($urandom_range(0, 400)) - 200);
            c.bias_second      = REG_WIDTH'(int'($urandom_range(0, 400)) - 200);
            c.start_act_first  = REG_WIDTH'(int'($urandom_range(0, 8191)) - 4096);
            c.start_act_second = REG_WIDTH'(int'($urandom_range(0, 1023)) - 512);
        end else if (style == 2) begin
            c.w_self_first     = corner_or_random();
            c.w_cross_first    = corner_or_random();
            c.w_self_second    = corner_or_random();
            c.w_cross_second   = corner_or_random();
            c.bias_first       = corner_or_random();
            c.bias_second      = corner_or_random();
            c.start_act_first  = corner_or_random();
            c.start_act_second = corner_or_random();
        end else begin
            c = {$urandom, $urandom, $urandom, $urandom};
        end
        return c;
    endfunction

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (tick_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [REG_WIDTH-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
    endtask

    task automatic load_cfg(t_cfg c);
        settle();
        write_reg(REG_W_SELF_FIRST,     c.w_self_first);
        write_reg(REG_W_CROSS_FIRST,    c.w_cross_first);
        write_reg(REG_W_SELF_SECOND,    c.w_self_second);
        write_reg(REG_W_CROSS_SECOND,   c.w_cross_second);
        write_reg(REG_BIAS_FIRST,       c.bias_first);
        write_reg(REG_BIAS_SECOND,      c.bias_second);
        write_reg(REG_START_ACT_FIRST,  c.start_act_first);
        write_reg(REG_START_ACT_SECOND, c.start_act_second);
        i_cfg_wr_en <= 1'b0;
        osc_cfg = c;
    endtask

    // one tick transaction; a typed result replaces the predicted one
    task automatic send_tick(bit restart, bit typed, t_tick_result typed_res);
        t_tick_result res;
        int           gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - 1){1'b0}}, restart};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        res = predict_tick(restart);
        tick_results_due.push_back(typed ? typed_res : res);
    endtask

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
            rx_hold    <= pick_gap();
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tick_result got;
        t_tick_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.out_first       = o_m_tdata[13:0];
            got.out_second      = o_m_tdata[27:14];
            got.act_first_next  = o_m_tdata[43:28];
            got.act_second_next = o_m_tdata[59:44];
            if (tick_results_due.size() == 0) begin
                if (fault_count < 10) begin
                    $display("unexpected result transaction: %0d %0d %0d %0d",
                             got.out_first, got.out_second,
                             got.act_first_next, got.act_second_next);
                end
                fault_count++;
            end else begin
                want = tick_results_due.pop_front();
                if (got.out_first !== want.out_first || got.out_second !== want.out_second
                        || got.act_first_next !== want.act_first_next
                        || got.act_second_next !== want.act_second_next) begin
                    if (fault_count < 10) begin
                        $display("result mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.out_first, want.out_second,
                                 want.act_first_next, want.act_second_next,
                                 got.out_first, got.out_second,
                                 got.act_first_next, got.act_second_next);
                    end
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("FAIL so2_oscillator_step_unit");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        longint unsigned one_q32;
        longint unsigned y;
        longint unsigned term;
        longint unsigned b;
        longint unsigned t;
        longint          bsum;
        t_tick_result    typed_res;
        int              cur_set;

        // tanh of magnitudes: decay factor from a truncated series, then one entry per step
        one_q32 = 64'd1 << 32;
        y       = (one_q32 * 16) / TANH_DEPTH;
        term    = one_q32;
        bsum    = 0;
        for (int n = 0; n < 20; n++) begin
            bsum = (n % 2 == 1) ? bsum - longint'(term) : bsum + longint'(term);
            term = ((term * y) >> 32) / 64'(n + 1);
        end
        if (bsum < 0) begin
            bsum = 0;
        end
        if (bsum > longint'(one_q32)) begin
            bsum = longint'(one_q32);
        end
        b = unsigned'(bsum);
        t = one_q32;
        for (int k = 0; k < TANH_DEPTH; k++) begin
            tanh_mag_lut[k] = 32'((64'd8192 * (one_q32 - t) + one_q32 + t)
                                  / (64'd2 * (one_q32 + t)));
            t = (t * b) >> 32;
        end
        osc_cfg        = directed_cfgs[0];
        osc_act_first  = 0;
        osc_act_second = 0;
        cur_set        = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg_set != cur_set) begin
                cur_set = directed_rows[r].cfg_set;
                load_cfg(directed_cfgs[cur_set]);
            end
            typed_res.out_first       = OUT_WIDTH'(directed_rows[r].out_first);
            typed_res.out_second      = OUT_WIDTH'(directed_rows[r].out_second);
            typed_res.act_first_next  = ACT_OUT_WIDTH'(directed_rows[r].act_first);
            typed_res.act_second_next = ACT_OUT_WIDTH'(directed_rows[r].act_second);
            send_tick(directed_rows[r].restart, directed_rows[r].typed, typed_res);
        end

        // each phase starts from its start values, with an occasional restart mid-run
        for (int p = 0; p < N_PHASES; p++) begin
            load_cfg(rand_cfg(p % 3));
            tx_idle_on  = (p % 4 != 0);
            rx_stall_on = (p % 4 != 0);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                send_tick(n == 0 || $urandom_range(0, 15) == 0, 1'b0, '0);
            end
        end

        settle();
        fault_count += tick_results_due.size();
        if (fault_count == 0) begin
            $display("PASS so2_oscillator_step_unit");
        end else begin
            $display("FAIL so2_oscillator_step_unit");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/so2osc_pkg.sv
rtl/so2_cfg_regs.sv
rtl/so2_neuron.sv
rtl/so2_tanh_rom.sv
rtl/so2_oscillator_step_unit.sv
verif/so2_oscillator_step_unit_test.sv
